>>> design/assert_macros.svh
// Assertion macros shared by the transposition table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked non-overlapping: the consequent follows its antecedent.
`define TTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ttu_pkg.sv
// Types, constants and register codes shared by the transposition table modules.
`timescale 1ns / 1ps

package ttu_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam logic [14:0] MATE_SCORE_RST = 15'd20000;
    localparam logic [30:0] GENERATION_RST = 31'd0;

    // Command codes.
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // Bound kinds.
    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic REG_MATE_SCORE = 1'b0;
    localparam logic REG_GENERATION = 1'b1;

    typedef struct packed {
        logic               command;
        logic [63:0]        key;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [7:0]  search_depth;
        logic signed [15:0] score;
        logic [31:0]        move_word;
        logic [1:0]         bound_kind;
        logic               time_up;
    } item_t;

    typedef struct packed {
        logic               value_hit;
        logic signed [15:0] value_out;
        logic [31:0]        best_move_out;
        logic               written;
    } result_t;

    typedef struct packed {
        logic [63:0]        key;
        logic [6:0]         depth;
        logic [31:0]        stamp;
        logic signed [15:0] value;
        logic [31:0]        move;
        logic [1:0]         kind;
    } entry_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read;
        logic commit;
    } ttu_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } ttu_status_t;

endpackage

>>> design/ttu_ctrl.sv
// Controller state machine that sequences clearing, read and evaluation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttu_ctrl
    import ttu_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  ttu_status_t status,
    output ttu_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_EVAL;
            S_EVAL:
            begin
                if (!status.out_blocked)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.load       = (state_reg == S_IDLE) && item_valid;
        cmd.read       = (state_reg == S_READ);
        cmd.commit     = (state_reg == S_EVAL) && !status.out_blocked;
    end

    assign item_stall = stall_reg;

    `TTU_ASSERT(a_stall_tracks_idle, stall_reg == (state_reg != S_IDLE), "stall out of step with state")
    `TTU_ASSERT_NEXT(a_read_then_eval, cmd.read, state_reg == S_EVAL, "read not followed by evaluation")

endmodule

>>> design/ttu_datapath.sv
// Datapath: item register, entry memory, evaluation and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttu_datapath
    import ttu_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ttu_cmd_t    cmd,
    output ttu_status_t status,
    input  item_t       item,
    input  logic [14:0] mate_score,
    input  logic [30:0] search_generation,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam bit          IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    item_t             item_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    entry_t            rd_reg;
    entry_t            mem [TABLE_ENTRIES];
    logic              result_valid_reg;
    result_t           result_reg;

    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  mem_addr;
    logic              mem_we;
    entry_t            mem_wdata;

    logic                match;
    logic signed [8:0]   depth9;
    logic signed [8:0]   entry_depth9;
    logic                depth_pos;
    logic signed [16:0]  score17;
    logic signed [16:0]  mate17;
    logic [31:0]         stamp;
    logic                skip_base;
    logic                do_write;
    result_t             result_next;

    // The table size is a power of two, so the slot is the low key bits.
    assign idx = item_reg.key[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_step)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    // Evaluation of the registered entry against the held item.
    assign match        = (rd_reg.key == item_reg.key);
    assign depth9       = {item_reg.search_depth[7], item_reg.search_depth};
    assign entry_depth9 = $signed({2'b00, rd_reg.depth});
    assign depth_pos    = (item_reg.search_depth >= 8'sd1);
    assign score17      = {item_reg.score[15], item_reg.score};
    assign mate17       = $signed({2'b00, mate_score});
    assign stamp        = {1'b0, search_generation} + {{24{1'b0}}, item_reg.search_depth};

    assign skip_base = item_reg.time_up || !depth_pos || (score17 >= mate17)
                       || (score17 <= -mate17);
    assign do_write  = (item_reg.command == CMD_STORE) && !skip_base
                       && !(match && (entry_depth9 > depth9))
                       && !(rd_reg.stamp >= stamp);

    always_comb
    begin
        result_next = '0;
        if (item_reg.command == CMD_PROBE)
        begin
            if (match)
            begin
                result_next.best_move_out = rd_reg.move;
                if (depth_pos && (entry_depth9 >= depth9))
                begin
                    priority if (rd_reg.kind == KIND_EXACT)
                    begin
                        result_next.value_hit = 1'b1;
                        result_next.value_out = rd_reg.value;
                    end
                    else if (rd_reg.kind == KIND_UPPER && rd_reg.value <= item_reg.alpha)
                    begin
                        result_next.value_hit = 1'b1;
                        result_next.value_out = item_reg.alpha;
                    end
                    else if (rd_reg.kind == KIND_LOWER && rd_reg.value >= item_reg.beta)
                    begin
                        result_next.value_hit = 1'b1;
                        result_next.value_out = item_reg.beta;
                    end
                    else
                    begin
                        result_next.value_hit = 1'b0;
                    end
                end
            end
        end
        else
        begin
            result_next.written = do_write;
        end
    end

    always_comb
    begin
        mem_wdata = '0;
        mem_we    = cmd.clear_step || (cmd.commit && do_write);
        mem_addr  = cmd.clear_step ? clr_addr_reg : idx;
        if (!cmd.clear_step)
        begin
            mem_wdata.key   = item_reg.key;
            mem_wdata.depth = item_reg.search_depth[6:0];
            mem_wdata.stamp = stamp;
            mem_wdata.value = item_reg.score;
            mem_wdata.move  = item_reg.move_word;
            mem_wdata.kind  = item_reg.bound_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.read)
            rd_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.commit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            result_reg <= result_next;
    end

    assign status.clear_last  = cmd.clear_step && (clr_addr_reg == LAST_IDX);
    assign status.out_blocked = result_valid_reg && result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TTU_ASSERT(a_pow2_entries, IS_POW2, "table size is not a power of two")
    `TTU_ASSERT(a_hit_xor_write, !(result_valid_reg && result_reg.value_hit && result_reg.written), "result both hit and written")
    `TTU_ASSERT(a_miss_zero, !(result_valid_reg && !result_reg.value_hit && result_reg.value_out != 16'sd0), "value without hit")

endmodule

>>> design/transposition_table_unit.sv
// Top level of the transposition table: configuration registers and unit wiring.
`timescale 1ns / 1ps

// Usage
// A probe or store arrives as one transfer on the item channel (item_valid,
// item_stall, item) and produces exactly one transfer on the result channel
// (result_valid, result_stall, result). Results come back in item order.
// TABLE_ENTRIES is a power of two and the slot is the low bits of the key.
// An item is accepted, its slot is read in the following cycle and evaluated
// in the one after; a new item is taken only once the result of the last one
// has been committed to the result register. After reset the unit sweeps
// all TABLE_ENTRIES slots (4096 by default) of the entry memory to zero,
// one slot per cycle, with item_stall held high.
// When the receiver stalls, the finished result holds in its register while
// the next item may already be accepted and read; evaluation waits until the
// result register frees up. mate_score (byte 0) and search_generation (byte 4)
// must be written over APB only while the unit is idle, which it does not enforce.

module transposition_table_unit
    import ttu_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic [14:0] mate_score_reg;
    logic [30:0] generation_reg;
    logic        cfg_write;
    ttu_cmd_t    cmd;
    ttu_status_t status;

    // The register index is taken from the word address bit.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mate_score_reg <= MATE_SCORE_RST;
            generation_reg <= GENERATION_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MATE_SCORE: mate_score_reg <= pwdata[14:0];
                REG_GENERATION: generation_reg <= pwdata[30:0];
                default:        mate_score_reg <= mate_score_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MATE_SCORE: prdata = {17'd0, mate_score_reg};
            REG_GENERATION: prdata = {1'b0, generation_reg};
            default:        prdata = '0;
        endcase
    end

    ttu_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ttu_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .item              (item),
        .mate_score        (mate_score_reg),
        .search_generation (generation_reg),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result)
    );

endmodule
